>>> sv/suc_pkg.sv
package suc_pkg;

    // Width of one set element.
    localparam int VALUE_W = 32;

    // Default capacity of the sorted store.
    localparam int DEPTH_DEFAULT = 64;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Word on the input channel.
    typedef struct packed {
        value_t value;
        logic   last;
    } in_word_t;

    // Word on the output channel.
    typedef struct packed {
        value_t unique_value;
        logic   final_res;
        logic   overflow;
    } out_word_t;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_one;
    } dp_status_t;

endpackage

>>> sv/suc_ctrl.sv
module suc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    input  logic                  src_last,
    output logic                  src_stall,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    input  suc_pkg::dp_status_t   status,
    output suc_pkg::dp_cmd_t      cmd
);
    import suc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.insert    = 1'b0;
        cmd.shift_out = 1'b0;
        src_stall     = 1'b1;
        dst_valid     = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                src_stall = 1'b0;
                if (src_valid)
                begin
                    cmd.insert = 1'b1;
                    if (src_last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                dst_valid = 1'b1;
                if (!dst_stall)
                begin
                    cmd.shift_out = 1'b1;
                    if (status.last_one)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> sv/suc_datapath.sv
module suc_datapath #(
    parameter int DEPTH = suc_pkg::DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  suc_pkg::dp_cmd_t      cmd,
    input  suc_pkg::value_t       din,
    output suc_pkg::value_t       head,
    output logic                  ovf,
    output suc_pkg::dp_status_t   status
);
    import suc_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    value_t           cells_reg [DEPTH];
    value_t           cells_next [DEPTH];
    logic [DEPTH-1:0] below;
    logic [DEPTH-1:0] match;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             dup;
    logic             full;
    logic             do_insert;

    // Every occupied cell compares its entry with the incoming word.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            below[i] = (CNT_W'(i) < occ_reg) && (cells_reg[i] < din);
            match[i] = (CNT_W'(i) < occ_reg) && (cells_reg[i] == din);
        end
    end

    assign dup       = |match;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign do_insert = cmd.insert && !dup && !full;

    // Cell chain: insert shifts the upper part up by one, output shifts down.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        if (do_insert)
        begin
            if (!below[0])
            begin
                cells_next[0] = din;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!below[i])
                begin
                    cells_next[i] = below[i-1] ? din : cells_reg[i-1];
                end
            end
        end
        else if (cmd.shift_out)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                cells_next[i] = cells_reg[i+1];
            end
        end
    end

    // Occupancy and overflow flag.
    always_comb
    begin
        occ_next = occ_reg;
        ovf_next = ovf_reg;
        if (cmd.insert)
        begin
            if (do_insert)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
            else if (!dup)
            begin
                ovf_next = 1'b1;
            end
        end
        else if (cmd.shift_out)
        begin
            occ_next = occ_reg - CNT_W'(1);
            if (occ_reg == CNT_W'(1))
            begin
                ovf_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            ovf_reg <= ovf_next;
        end
    end

    // Cell registers hold payload only.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    assign head            = cells_reg[0];
    assign ovf             = ovf_reg;
    assign status.last_one = (occ_reg == CNT_W'(1));

endmodule

>>> sv/sorted_unique_collector.sv
// Sorted unique collector.
// The src channel (src_valid, src_stall, src_word) takes one signed 32-bit
// value per word; the word with last set closes the set. Each word is placed
// in a chain of DEPTH compare-and-shift cells in the cycle it is accepted,
// so loading runs at one word per cycle and duplicates are dropped there.
// After the closing word the dst channel (dst_valid, dst_stall, dst_word)
// gives the distinct values in ascending signed order, one word per cycle
// while dst_stall is low, starting the cycle after the closing word;
// final_res marks the last one. src_stall is high while the values are
// emitted. Values beyond DEPTH distinct ones are dropped and overflow is
// set on every word of that set. While dst_stall is high the chain holds and
// dst_word does not change. Reset empties the store, clears the overflow flag
// and puts the block in the loading state.
module sorted_unique_collector #(
    parameter int DEPTH = suc_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  suc_pkg::in_word_t    src_word,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output suc_pkg::out_word_t   dst_word
);
    import suc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    value_t     head;
    logic       ovf;

    // Sequencer for the load and output phases.
    suc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_last  (src_word.last),
        .src_stall (src_stall),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Sorted cell chain with occupancy and overflow.
    suc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .din    (src_word.value),
        .head   (head),
        .ovf    (ovf),
        .status (status)
    );

    assign dst_word.unique_value = head;
    assign dst_word.final_res    = status.last_one;
    assign dst_word.overflow     = ovf;

`ifndef ASSERT_OFF
    // A closing word starts the output phase in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall && src_word.last) |=> dst_valid)
    else $error("output phase did not start after closing word");

    // After the final word is taken the block returns to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_stall && dst_word.final_res) |=> (!dst_valid && !src_stall))
    else $error("block did not return to loading after final word");

    // Within one set the output continues and the overflow flag is constant.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_stall && !dst_word.final_res)
            |=> (dst_valid && $stable(dst_word.overflow)))
    else $error("output phase broke off or overflow changed within a set");

    // Loading and output never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> src_stall)
    else $error("input accepted while results pending");
`endif

endmodule

>>> tb/sorted_unique_collector_tb.sv
module sorted_unique_collector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import suc_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 10;
    localparam int N_DIRECTED = 22;

    localparam value_t VAL_MIN = 32'sh8000_0000;
    localparam value_t VAL_MAX = 32'sh7FFF_FFFF;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Single-value sets right after reset and at the extremes.
        '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{VAL_MIN, 1'b1}, 1'b1, '{VAL_MIN, 1'b1, 1'b0}},
        '{'{VAL_MAX, 1'b1}, 1'b1, '{VAL_MAX, 1'b1, 1'b0}},
        '{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
        // Extremes mixed in one set; no wrap-around in the compare.
        '{'{VAL_MAX, 1'b0}, 1'b0, '0},
        '{'{VAL_MIN, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 1'b0}, 1'b0, '0},
        '{'{-32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b1}, 1'b0, '0},
        // Repeated values collapse to one.
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{-32'sd5, 1'b0}, 1'b0, '0},
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{-32'sd5, 1'b1}, 1'b0, '0},
        // The closing word is itself a repeat.
        '{'{32'sd7, 1'b0}, 1'b0, '0},
        '{'{32'sd3, 1'b0}, 1'b0, '0},
        '{'{32'sd7, 1'b1}, 1'b0, '0},
        // Values one step inside the extremes.
        '{'{32'sh7FFF_FFFE, 1'b0}, 1'b0, '0},
        '{'{32'sh8000_0001, 1'b0}, 1'b0, '0},
        '{'{32'sh7FFF_FFFE, 1'b1}, 1'b0, '0},
        // Alternating bit patterns.
        '{'{32'shAAAA_AAAA, 1'b0}, 1'b0, '0},
        '{'{32'sh5555_5555, 1'b1}, 1'b0, '0}
    };

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    in_word_t  src_word;
    logic      dst_valid;
    logic      dst_stall;
    out_word_t dst_word;

    // Copy of the store kept by the predictor.
    value_t sorted_copy [STORE_DEPTH];
    int     copy_fill = 0;
    bit     copy_dropped = 1'b0;

    out_word_t set_words[$];
    out_word_t awaited_words[$];

    int mismatch_count = 0;
    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    bit hold_request = 1'b0;

    sorted_unique_collector #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_word(src_word),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_word(dst_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Insert one accepted value into the copy; a closing word fills set_words.
    function automatic void merge_value(in_word_t w);
        int pos;
        int i;
        out_word_t ow;
        set_words.delete();
        pos = 0;
        while (pos < copy_fill && $signed(sorted_copy[pos]) < $signed(w.value))
            pos++;
        if (!(pos < copy_fill && sorted_copy[pos] == w.value))
        begin
            if (copy_fill >= STORE_DEPTH)
                copy_dropped = 1'b1;
            else
            begin
                for (i = copy_fill; i > pos; i--)
                    sorted_copy[i] = sorted_copy[i - 1];
                sorted_copy[pos] = w.value;
                copy_fill++;
            end
        end
        if (w.last)
        begin
            for (i = 0; i < copy_fill; i++)
            begin
                ow.unique_value = sorted_copy[i];
                ow.final_res = (i == copy_fill - 1);
                ow.overflow = copy_dropped;
                set_words.push_back(ow);
            end
            copy_fill = 0;
            copy_dropped = 1'b0;
        end
    endfunction

    // Offer one word, entered and left just after a falling edge.
    task automatic send_word(in_word_t w, logic typed, out_word_t want);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_word <= w;
        do
            @(posedge clk);
        while (src_stall);
        merge_value(w);
        if (typed)
            awaited_words.push_back(want);
        else
            foreach (set_words[k])
                awaited_words.push_back(set_words[k]);
        @(negedge clk);
    endtask

    // Random values: full range, a narrow band that repeats, and the extremes.
    function automatic value_t pick_value();
        case ($urandom_range(0, 3))
            1: return value_t'(int'($urandom_range(0, 15)) - 8);
            2:
            begin
                case ($urandom_range(0, 6))
                    0: return VAL_MIN;
                    1: return VAL_MIN + 1;
                    2: return -32'sd1;
                    3: return 32'sd0;
                    4: return 32'sd1;
                    5: return VAL_MAX - 1;
                    default: return VAL_MAX;
                endcase
            end
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic send_random_set(int n);
        in_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.value = pick_value();
            w.last = (i == n - 1);
            send_word(w, 1'b0, '0);
        end
    endtask

    // Fill the store exactly; with spill set, more words follow, a repeat and
    // new values that are dropped, the closing one among them.
    task automatic send_full_set(bit spill);
        value_t base;
        in_word_t w;
        base = value_t'(int'($urandom_range(0, 2000000)) - 1000000);
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            w.value = base + value_t'(((i * 37) % STORE_DEPTH) * 3);
            w.last = 1'b0;
            send_word(w, 1'b0, '0);
        end
        // A repeat while full must not raise the overflow flag.
        w.value = base + 32'sd15;
        w.last = !spill;
        send_word(w, 1'b0, '0);
        if (spill)
        begin
            w.value = base - 32'sd7;
            w.last = 1'b0;
            send_word(w, 1'b0, '0);
            w.value = base + 32'sd30;
            send_word(w, 1'b0, '0);
            w.value = VAL_MIN;
            w.last = 1'b1;
            send_word(w, 1'b0, '0);
        end
    endtask

    // Receiver side: random stall, or a long hold when asked for.
    initial
    begin : receiver
        dst_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);
        end
    end

    // Compare each accepted output word with the oldest awaited one.
    always @(posedge clk)
    begin : check_output
        out_word_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, got value %0d final %0b ovf %0b",
                         $time, dst_word.unique_value, dst_word.final_res,
                         dst_word.overflow);
                mismatch_count++;
            end
            else
            begin
                want = awaited_words.pop_front();
                if (dst_word.unique_value !== want.unique_value ||
                    dst_word.final_res !== want.final_res ||
                    dst_word.overflow !== want.overflow)
                begin
                    $display("%0t ns: expected value %0d final %0b ovf %0b",
                             $time, want.unique_value, want.final_res, want.overflow);
                    $display("%0t ns: got      value %0d final %0b ovf %0b",
                             $time, dst_word.unique_value, dst_word.final_res,
                             dst_word.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int phase_items;
        int n;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_word = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        for (int r = 0; r < N_DIRECTED; r++)
            send_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // Random sets over the idling phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    dst_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 71;
                    dst_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    dst_stall_pct = 71;
                end
                default:
                begin
                    src_idle_pct = 29;
                    dst_stall_pct = 29;
                end
            endcase
            // The receiver holds off while words keep coming, so the block
            // backs up and stalls its input.
            if (phase == 0)
                hold_request = 1'b1;
            if (phase == 1)
                send_full_set(1'b0);
            if (phase == 2)
                send_full_set(1'b1);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                n = $urandom_range(1, 12);
                send_random_set(n);
                phase_items += n;
            end
        end
        src_valid <= 1'b0;

        // Drain the outstanding words, then let the clock run on quietly.
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
